// ===== hw/rtl/modem_response_keyword_matcher_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the modem response keyword matcher
// Shared concurrent assertion forms, clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef MODEM_RESPONSE_KEYWORD_MATCHER_UNIT_ASSERT_SVH
`define MODEM_RESPONSE_KEYWORD_MATCHER_UNIT_ASSERT_SVH

// Check a condition at every clock edge out of reset.
`define MRKM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define MRKM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define MRKM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mrkm_pkg.sv =====
// ----------------------------------------------------------------------------
// Modem response keyword matcher package
// Types and fixed constants shared by the matcher modules.
// ----------------------------------------------------------------------------
package mrkm_pkg;

  localparam int BYTE_W     = 8;
  localparam int HIST_DEPTH = 7;
  localparam int FILL_W     = 8;

  typedef logic [BYTE_W-1:0]                 byte_t;
  typedef logic [HIST_DEPTH-1:0][BYTE_W-1:0] window_t;
  typedef logic [FILL_W-1:0]                 fill_t;

  typedef enum logic [1:0] {
    PH_AT    = 2'd0,
    PH_CLASS = 2'd1,
    PH_RUN   = 2'd2,
    PH_OFF   = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    EV_NONE    = 4'd0,
    EV_OK      = 4'd1,
    EV_CLASS   = 4'd2,
    EV_START   = 4'd3,
    EV_RX      = 4'd4,
    EV_ACK     = 4'd5,
    EV_DONE    = 4'd6,
    EV_BUSY    = 4'd7,
    EV_NO_CHAN = 4'd8
  } event_t;

  // Result of one pass of the keyword compare.
  typedef struct packed {
    event_t event_res;
    byte_t  server_byte;
    logic   kw_clear;
  } match_t;

endpackage

// ===== hw/rtl/mrkm_match.sv =====
// ----------------------------------------------------------------------------
// Keyword compare
// Parallel compares of the byte window against the keywords of one phase.
// ----------------------------------------------------------------------------
module mrkm_match (
  input  mrkm_pkg::phase_t  phase,
  input  mrkm_pkg::window_t win,
  output mrkm_pkg::match_t  res
);
  import mrkm_pkg::*;

  // Hex digit value; anything else passes through raw.
  function automatic byte_t hex_val(input byte_t c);
    byte_t v;
    v = c;
    if (c >= "0" && c <= "9") begin
      v = c - "0";
    end else if (c >= "A" && c <= "F") begin
      v = c - "A" + 8'd10;
    end else if (c >= "a" && c <= "f") begin
      v = c - "a" + 8'd10;
    end
    return v;
  endfunction

  byte_t hi_val;
  byte_t lo_val;

  // win[k-1] holds the byte k places back, win[0] the newest.
  assign hi_val = hex_val(win[1]);
  assign lo_val = hex_val(win[0]);

  always_comb begin
    res.event_res   = EV_NONE;
    res.server_byte = '0;
    res.kw_clear    = 1'b0;
    unique case (phase)
      PH_AT: begin
        if (win[1] == "O" && win[0] == "K") begin
          res.event_res = EV_OK;
          res.kw_clear  = 1'b1;
        end
      end
      PH_CLASS: begin
        if (win[3] == "C" && win[2] == "L" && win[1] == "A" && win[0] == "S") begin
          res.event_res = EV_CLASS;
          res.kw_clear  = 1'b1;
        end
      end
      PH_RUN: begin
        priority if (win[4] == "S" && win[3] == "t" && win[2] == "a" &&
                     win[1] == "r" && win[0] == "t") begin
          res.event_res = EV_START;
        end else if (win[6] == "R" && win[5] == "X" && win[4] == ":") begin
          res.event_res   = EV_RX;
          res.server_byte = (hi_val << 4) | lo_val;
        end else if (win[5] == "A" && win[4] == "C" && win[3] == "K" &&
                     win[1] == "R" && win[0] == "e") begin
          res.event_res = EV_ACK;
        end else if (win[3] == "D" && win[2] == "o" && win[1] == "n" &&
                     win[0] == "e") begin
          res.event_res = EV_DONE;
        end else if (win[3] == "b" && win[2] == "u" && win[1] == "s" &&
                     win[0] == "y") begin
          res.event_res = EV_BUSY;
        end else if (win[4] == "N" && win[3] == "o" && win[1] == "f" &&
                     win[0] == "r") begin
          res.event_res = EV_NO_CHAN;
        end else begin
          res.event_res = EV_NONE;
        end
      end
      PH_OFF: begin
        res.event_res = EV_NONE;
      end
      default: begin
        res.event_res = EV_NONE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/modem_response_keyword_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// Modem response keyword matcher
// Watches the byte stream of an AT-command radio modem and reports one
// event code per received byte.
// ----------------------------------------------------------------------------
//
//  channel   ports                                 direction
//  --------  ------------------------------------  ---------
//  in        in_valid, in_stall, in_rx_byte        to block
//  out       out_valid, out_stall, out_event_res,  from block
//            out_server_byte
//  cfg       cfg_wr_en, cfg_wr_data (phase)        to block
//
//  One byte is taken every cycle while the input side is not stalled; its
//  result passes the input register, then the result register, before it
//  is offered and can be accepted.
//  The window compare and window update are combinational between those
//  two registers, which sets the one-byte-per-cycle throughput.
//  Reset (synchronous, active low) clears the window, the fill count, the
//  phase and both valid flags.
//  A stall on the result side holds the result register and the staged
//  byte; the input side stalls only once the staged byte cannot advance.
//
module modem_response_keyword_matcher_unit #(
  parameter int BUF_LIMIT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_event_res,
  output logic [7:0] out_server_byte,
  // configuration
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);
  import mrkm_pkg::*;

  `include "modem_response_keyword_matcher_unit_assert.svh"

  // Phase register
  phase_t  phase_r;

  // Input stage
  logic    s1_valid_r;
  byte_t   s1_byte_r;

  // Byte history and fill count since the last clear
  window_t hist_r;
  window_t hist_nxt;
  fill_t   fill_r;
  fill_t   fill_nxt;

  // Result register
  logic    out_valid_r;
  event_t  out_event_r;
  byte_t   out_byte_r;

  logic            advance;
  logic            in_take;
  window_t         win_shift;
  window_t         win_eff;
  logic [FILL_W:0] cnt;
  logic            overflow;
  logic            crlf;
  logic            buf_clear;
  match_t          match;

  // Advance the staged byte whenever the result register is free or drains.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Shift the new byte in and check the clear conditions.
  assign win_shift = {hist_r[HIST_DEPTH-2:0], s1_byte_r};
  assign cnt       = {1'b0, fill_r} + {{FILL_W{1'b0}}, 1'b1};
  assign overflow  = cnt > (FILL_W+1)'(BUF_LIMIT);
  assign crlf      = (win_shift[1] == 8'h0D) && (win_shift[0] == 8'h0A);
  assign buf_clear = overflow || crlf;

  // A cleared window reads as zero bytes, so nothing matches across a clear.
  assign win_eff = buf_clear ? '0 : win_shift;

  mrkm_match u_match (
    .phase (phase_r),
    .win   (win_eff),
    .res   (match)
  );

  // Drop the whole window on a clear or after an OK / CLAS hit.
  always_comb begin
    if (buf_clear || match.kw_clear) begin
      hist_nxt = '0;
      fill_nxt = '0;
    end else begin
      hist_nxt = win_shift;
      fill_nxt = cnt[FILL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_AT;
      s1_valid_r  <= 1'b0;
      hist_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        phase_r <= phase_t'(cfg_wr_data);
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        hist_r      <= hist_nxt;
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: the staged byte loads on a take, the result on an advance; both hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
    if (advance) begin
      out_event_r <= match.event_res;
      out_byte_r  <= match.server_byte;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_res   = out_event_r;
  assign out_server_byte = out_byte_r;

  `MRKM_ASSERT_ALWAYS(a_fill_bound, fill_r <= FILL_W'(BUF_LIMIT), "fill count past limit")
  `MRKM_ASSERT_NEXT(a_kw_clears, advance && match.kw_clear, (hist_r == '0) && (fill_r == '0), "window not cleared after OK or CLAS")
  `MRKM_ASSERT_SAME(a_sb_zero, out_valid_r && (out_event_r != EV_RX), out_byte_r == '0, "server byte set without rx event")
  `MRKM_ASSERT_NEXT(a_stage_hold, s1_valid_r && !advance, s1_valid_r && $stable(s1_byte_r), "staged byte lost while stalled")

endmodule
